>>> sv/ir_pulse_decoder_motor_drive_assert.svh
// assertion macros for the checker file
`ifndef IR_PULSE_DECODER_MOTOR_DRIVE_ASSERT_SVH
`define IR_PULSE_DECODER_MOTOR_DRIVE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define IRPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("irpd assertion failed");

// next-cycle implication, disabled while reset is low
`define IRPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("irpd assertion failed");

`endif

>>> sv/irpd_pkg.sv
`timescale 1ns / 1ps

package irpd_pkg;

  localparam int CODE_WIDTH_DEF = 16;

  // configuration register indexes
  localparam logic [2:0] CFG_START_MIN     = 3'd0;
  localparam logic [2:0] CFG_START_MAX     = 3'd1;
  localparam logic [2:0] CFG_ONE_SPLIT     = 3'd2;
  localparam logic [2:0] CFG_ONE_MAX       = 3'd3;
  localparam logic [2:0] CFG_ERROR_MIN     = 3'd4;
  localparam logic [2:0] CFG_FRAME_LEN     = 3'd5;
  localparam logic [2:0] CFG_TIMEOUT_TICKS = 3'd6;

  // register reset values
  localparam logic [15:0] START_MIN_RST     = 16'd1050;
  localparam logic [15:0] START_MAX_RST     = 16'd1200;
  localparam logic [15:0] ONE_SPLIT_RST     = 16'd380;
  localparam logic [15:0] ONE_MAX_RST       = 16'd600;
  localparam logic [15:0] ERROR_MIN_RST     = 16'd800;
  localparam logic [5:0]  FRAME_LEN_RST     = 6'd24;
  localparam logic [15:0] TIMEOUT_TICKS_RST = 16'd200;

  // item kinds
  localparam logic CMD_PULSE = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // button codes
  localparam logic [31:0] BTN_FWD       = 32'hF8C7;
  localparam logic [31:0] BTN_BACK      = 32'hFA55;
  localparam logic [31:0] BTN_FWD_RIGHT = 32'hFBD4;
  localparam logic [31:0] BTN_FWD_LEFT  = 32'hF986;
  localparam logic [31:0] BTN_BACK_RIGHT = 32'hFA95;
  localparam logic [31:0] BTN_BACK_LEFT = 32'hFA15;

  // motor drive patterns: right back, right fwd, left fwd, left back
  localparam logic [3:0] DRV_FWD        = 4'h6;
  localparam logic [3:0] DRV_BACK       = 4'h9;
  localparam logic [3:0] DRV_FWD_RIGHT  = 4'h4;
  localparam logic [3:0] DRV_FWD_LEFT   = 4'h2;
  localparam logic [3:0] DRV_BACK_RIGHT = 4'h8;
  localparam logic [3:0] DRV_BACK_LEFT  = 4'h1;
  localparam logic [3:0] DRV_STOP       = 4'h0;

  typedef struct packed {
    logic [15:0] start_min;
    logic [15:0] start_max;
    logic [15:0] one_split;
    logic [15:0] one_max;
    logic [15:0] error_min;
    logic [5:0]  frame_len;
    logic [15:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [5:0]  bit_count;
    logic        frame_open;
    logic [15:0] timeout_count;
    logic        timer_running;
    logic [3:0]  drive_bits;
  } ctl_state_t;

  typedef struct packed {
    logic done;
    logic err;
  } flags_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] drive;
  } btn_match_t;

  function automatic btn_match_t btn_lookup(input logic [31:0] code);
    btn_match_t m;
    m.hit = 1'b1;
    case (code)
      BTN_FWD:        m.drive = DRV_FWD;
      BTN_BACK:       m.drive = DRV_BACK;
      BTN_FWD_RIGHT:  m.drive = DRV_FWD_RIGHT;
      BTN_FWD_LEFT:   m.drive = DRV_FWD_LEFT;
      BTN_BACK_RIGHT: m.drive = DRV_BACK_RIGHT;
      BTN_BACK_LEFT:  m.drive = DRV_BACK_LEFT;
      default: begin
        m.hit   = 1'b0;
        m.drive = DRV_STOP;
      end
    endcase
    return m;
  endfunction

endpackage

>>> sv/irpd_core.sv
`timescale 1ns / 1ps

module irpd_core #(
  parameter int CODE_WIDTH = irpd_pkg::CODE_WIDTH_DEF
) (
  input  irpd_pkg::cfg_t         cfg,
  input  irpd_pkg::ctl_state_t   st,
  input  logic [CODE_WIDTH-1:0]  code,
  input  logic                   command,
  input  logic [15:0]            pulse_width,
  output irpd_pkg::ctl_state_t   st_nxt,
  output logic [CODE_WIDTH-1:0]  code_nxt,
  output irpd_pkg::flags_t       flags
);

  always_comb begin
    irpd_pkg::ctl_state_t s;
    irpd_pkg::btn_match_t m;
    logic [CODE_WIDTH-1:0] cd;
    logic                  done;
    logic                  err;
    s    = st;
    cd   = code;
    done = 1'b0;
    err  = 1'b0;
    m    = irpd_pkg::btn_lookup(32'(code));
    if (command == irpd_pkg::CMD_PULSE) begin
      // checks run in order, each on the state left by the one before
      if (s.bit_count == 6'd1 && pulse_width > cfg.error_min) begin
        s.frame_open = 1'b0;
        s.bit_count  = 6'd0;
        cd           = '0;
        err          = 1'b1;
      end
      if (pulse_width > cfg.start_min && pulse_width < cfg.start_max &&
          s.bit_count == 6'd0) begin
        cd           = '0;
        s.frame_open = 1'b1;
        s.bit_count  = s.bit_count + 6'd1;
      end
      if (s.frame_open && pulse_width != 16'd0 && pulse_width < cfg.one_split) begin
        cd          = {cd[CODE_WIDTH-2:0], 1'b0};
        s.bit_count = s.bit_count + 6'd1;
      end
      if (s.frame_open && pulse_width > cfg.one_split && pulse_width < cfg.one_max) begin
        cd          = {cd[CODE_WIDTH-2:0], 1'b1};
        s.bit_count = s.bit_count + 6'd1;
      end
      m = irpd_pkg::btn_lookup(32'(cd));
      if (s.bit_count == cfg.frame_len) begin
        s.frame_open = 1'b0;
        s.bit_count  = 6'd0;
        done         = 1'b1;
        if (m.hit) begin
          s.drive_bits    = m.drive;
          s.timer_running = 1'b1;
        end
      end
    end else if (s.timer_running) begin
      s.timeout_count = s.timeout_count + 16'd1;
      if (s.timeout_count >= cfg.timeout_ticks) begin
        s.timeout_count = 16'd0;
        s.timer_running = 1'b0;
        s.drive_bits    = irpd_pkg::DRV_STOP;
        cd              = '0;
      end
    end
    st_nxt     = s;
    code_nxt   = cd;
    flags.done = done;
    flags.err  = err;
  end

endmodule

>>> sv/ir_pulse_decoder_motor_drive.sv
`timescale 1ns / 1ps
// an accepted input word passes through the input reg, then the result reg
// throughput: 1 word per cycle unless stalled, set by the single-pass decode between the two registers
// the input register only stalls while the result register is full and out_ready is low
// reset (rst_n low, synchronous): config returns to defaults, frame closed,
// timer stopped, motors off, code cleared, both stages empty

module ir_pulse_decoder_motor_drive #(
  parameter int CODE_WIDTH = irpd_pkg::CODE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input words
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_command,
  input  logic [15:0] in_pulse_width,
  // result words
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_motor_drive,
  output logic [15:0] out_ir_code,
  output logic        out_frame_done,
  output logic        out_frame_error,
  output logic        out_receiving,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  irpd_pkg::cfg_t cfg_r;

  // decoder state
  irpd_pkg::ctl_state_t  st_r;
  irpd_pkg::ctl_state_t  st_nxt;
  logic [CODE_WIDTH-1:0] code_r;
  logic [CODE_WIDTH-1:0] code_nxt;
  irpd_pkg::flags_t      flags;

  // input stage
  logic        s1_valid_r;
  logic        s1_command_r;
  logic [15:0] s1_width_r;

  // result stage
  logic        out_valid_r;
  logic [3:0]  out_motor_drive_r;
  logic [15:0] out_ir_code_r;
  logic        out_frame_done_r;
  logic        out_frame_error_r;
  logic        out_receiving_r;

  logic out_free;
  logic s1_move;

  // result slot frees when empty or being taken this cycle
  assign out_free  = !out_valid_r || out_ready;
  assign s1_move   = s1_valid_r && out_free;
  assign in_ready  = !s1_valid_r || out_free;
  assign cfg_ready = 1'b1;

  // config writes, only issued while idle: binds the user, the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_min     <= irpd_pkg::START_MIN_RST;
      cfg_r.start_max     <= irpd_pkg::START_MAX_RST;
      cfg_r.one_split     <= irpd_pkg::ONE_SPLIT_RST;
      cfg_r.one_max       <= irpd_pkg::ONE_MAX_RST;
      cfg_r.error_min     <= irpd_pkg::ERROR_MIN_RST;
      cfg_r.frame_len     <= irpd_pkg::FRAME_LEN_RST;
      cfg_r.timeout_ticks <= irpd_pkg::TIMEOUT_TICKS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        irpd_pkg::CFG_START_MIN:     cfg_r.start_min     <= cfg_data;
        irpd_pkg::CFG_START_MAX:     cfg_r.start_max     <= cfg_data;
        irpd_pkg::CFG_ONE_SPLIT:     cfg_r.one_split     <= cfg_data;
        irpd_pkg::CFG_ONE_MAX:       cfg_r.one_max       <= cfg_data;
        irpd_pkg::CFG_ERROR_MIN:     cfg_r.error_min     <= cfg_data;
        irpd_pkg::CFG_FRAME_LEN:     cfg_r.frame_len     <= cfg_data[5:0];
        irpd_pkg::CFG_TIMEOUT_TICKS: cfg_r.timeout_ticks <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_command_r <= in_command;
      s1_width_r   <= in_pulse_width;
    end
  end

  // all per-word decode: window checks, shift, match, timeout
  irpd_core #(
    .CODE_WIDTH(CODE_WIDTH)
  ) u_core (
    .cfg        (cfg_r),
    .st         (st_r),
    .code       (code_r),
    .command    (s1_command_r),
    .pulse_width(s1_width_r),
    .st_nxt     (st_nxt),
    .code_nxt   (code_nxt),
    .flags      (flags)
  );

  // state commits as the word moves into the result register,
  // so the next word in the input stage already sees it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      code_r <= '0;
    end else if (s1_move) begin
      st_r   <= st_nxt;
      code_r <= code_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_motor_drive_r <= st_nxt.drive_bits;
      out_ir_code_r     <= 16'(code_nxt);
      out_frame_done_r  <= flags.done;
      out_frame_error_r <= flags.err;
      out_receiving_r   <= st_nxt.frame_open;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_motor_drive = out_motor_drive_r;
  assign out_ir_code     = out_ir_code_r;
  assign out_frame_done  = out_frame_done_r;
  assign out_frame_error = out_frame_error_r;
  assign out_receiving   = out_receiving_r;

endmodule

>>> sv/irpd_checker.sv
`timescale 1ns / 1ps
`include "ir_pulse_decoder_motor_drive_assert.svh"

module irpd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_command,
  input logic [15:0] in_pulse_width,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_motor_drive,
  input logic [15:0] out_ir_code,
  input logic        out_frame_done,
  input logic        out_frame_error,
  input logic        out_receiving,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [15:0] cfg_data
);

  // a stalled result word holds
  `IRPD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_motor_drive) && $stable(out_ir_code) && $stable(out_frame_done) && $stable(out_frame_error) && $stable(out_receiving))

  // input only backs up when the result slot is full and stalled
  `IRPD_ASSERT_NOW(a_in_stall, clk, rst_n, !in_ready, out_valid && !out_ready)

  // a completed frame is closed
  `IRPD_ASSERT_NOW(a_done_closed, clk, rst_n, out_valid && out_frame_done, !out_receiving)

  // an error that neither restarted nor completed a frame leaves the code cleared
  `IRPD_ASSERT_NOW(a_err_clear, clk, rst_n, out_valid && out_frame_error && !out_frame_done && !out_receiving, out_ir_code == 16'd0)

  // drive is off or one of the button patterns
  `IRPD_ASSERT_NOW(a_drive_legal, clk, rst_n, out_valid, out_motor_drive == 4'h0 || out_motor_drive == 4'h1 || out_motor_drive == 4'h2 || out_motor_drive == 4'h4 || out_motor_drive == 4'h6 || out_motor_drive == 4'h8 || out_motor_drive == 4'h9)

endmodule

bind ir_pulse_decoder_motor_drive irpd_checker u_irpd_checker (.*);
